[sv/rec_pkg.sv]
// Shared types, codes and reset values for the recovery escalation controller.
package rec_pkg;

  // Field widths
  localparam int unsigned ReqW   = 3;
  localparam int unsigned TickW  = 32;
  localparam int unsigned CntW   = 8;
  localparam int unsigned LvlW   = 2;
  localparam int unsigned ActW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 32;

  // Event codes
  localparam logic [ReqW-1:0] REQ_SUCCESS = 3'd0;
  localparam logic [ReqW-1:0] REQ_SNAPFAIL = 3'd1;
  localparam logic [ReqW-1:0] REQ_DESYNC  = 3'd2;
  localparam logic [ReqW-1:0] REQ_FORCE   = 3'd3;
  localparam logic [ReqW-1:0] REQ_RESET   = 3'd4;

  // Recovery levels
  localparam logic [LvlW-1:0] LVL_IDLE = 2'd0;
  localparam logic [LvlW-1:0] LVL_SOFT = 2'd1;
  localparam logic [LvlW-1:0] LVL_HARD = 2'd2;
  localparam logic [LvlW-1:0] LVL_DISC = 2'd3;

  // Requested actions
  localparam logic [ActW-1:0] ACT_NONE = 2'd0;
  localparam logic [ActW-1:0] ACT_SOFT = 2'd1;
  localparam logic [ActW-1:0] ACT_HARD = 2'd2;
  localparam logic [ActW-1:0] ACT_DISC = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_MAX_RETRIES  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_RECONN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WINDOW_TICKS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ESC_COUNT    = 3'd3;

  // Register reset values
  localparam logic [CntW-1:0]  RST_MAX_RETRIES  = 8'd3;
  localparam logic [CntW-1:0]  RST_MAX_RECONN   = 8'd3;
  localparam logic [TickW-1:0] RST_WINDOW_TICKS = 32'd600;
  localparam logic [CntW-1:0]  RST_ESC_COUNT    = 8'd3;

  localparam logic [CntW-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [CntW-1:0]  max_retries;
    logic [CntW-1:0]  max_reconn;
    logic [TickW-1:0] window_ticks;
    logic [CntW-1:0]  esc_count;
  } cfg_t;

  typedef struct packed {
    logic [LvlW-1:0]  level;
    logic [CntW-1:0]  retries;
    logic [CntW-1:0]  reconnects;
    logic [CntW-1:0]  desyncs;
    logic [TickW-1:0] win_start;
  } state_t;

  // Saturating counter increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[sv/rec_cfg.sv]
// Configuration register file of the recovery escalation controller.
module rec_cfg
  import rec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_idx_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; unknown indexes leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_idx_i)
        REG_MAX_RETRIES:  cfg_d.max_retries  = wr_data_i[CntW-1:0];
        REG_MAX_RECONN:   cfg_d.max_reconn   = wr_data_i[CntW-1:0];
        REG_WINDOW_TICKS: cfg_d.window_ticks = wr_data_i[TickW-1:0];
        REG_ESC_COUNT:    cfg_d.esc_count    = wr_data_i[CntW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_retries  <= RST_MAX_RETRIES;
      cfg_q.max_reconn   <= RST_MAX_RECONN;
      cfg_q.window_ticks <= RST_WINDOW_TICKS;
      cfg_q.esc_count    <= RST_ESC_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/rec_step.sv]
// Per-event next-state and action logic of the recovery escalation controller.
module rec_step
  import rec_pkg::*;
(
  input  logic [ReqW-1:0]  req_i,
  input  logic [TickW-1:0] tick_i,
  input  cfg_t             cfg_i,
  input  state_t           cur_i,
  output state_t           nxt_o,
  output logic [ActW-1:0]  action_o
);

  logic [CntW-1:0]  esc_reconn;
  logic [LvlW-1:0]  esc_level;
  logic [ActW-1:0]  esc_action;
  logic [CntW-1:0]  retry_inc;
  logic [TickW-1:0] ds_start;
  logic [TickW-1:0] ds_diff;
  logic             ds_expired;
  logic [CntW-1:0]  ds_count;

  // Escalation: bump reconnects, go to hard, or disconnect once past the limit
  always_comb begin
    esc_reconn = sat_inc(cur_i.reconnects);
    if (esc_reconn > cfg_i.max_reconn) begin
      esc_level  = LVL_DISC;
      esc_action = ACT_DISC;
    end else begin
      esc_level  = LVL_HARD;
      esc_action = ACT_HARD;
    end
  end

  // Desync window: open on first desync, restart when the window has run out
  always_comb begin
    ds_start   = (cur_i.desyncs == '0) ? tick_i : cur_i.win_start;
    ds_diff    = tick_i - ds_start;
    ds_expired = ds_diff > cfg_i.window_ticks;
    ds_count   = sat_inc(ds_expired ? '0 : cur_i.desyncs);
  end

  assign retry_inc = sat_inc(cur_i.retries);

  // Event dispatch
  always_comb begin
    nxt_o    = cur_i;
    action_o = ACT_NONE;
    case (req_i)
      REQ_SUCCESS: begin
        nxt_o.retries    = '0;
        nxt_o.reconnects = '0;
        nxt_o.desyncs    = '0;
        nxt_o.level      = LVL_IDLE;
      end
      REQ_SNAPFAIL: begin
        nxt_o.retries = retry_inc;
        if (cur_i.level == LVL_IDLE) nxt_o.level = LVL_SOFT;
        if (retry_inc > cfg_i.max_retries) begin
          nxt_o.reconnects = esc_reconn;
          nxt_o.level      = esc_level;
          action_o         = esc_action;
        end else begin
          action_o = ACT_SOFT;
        end
      end
      REQ_DESYNC: begin
        nxt_o.win_start = ds_expired ? tick_i : ds_start;
        nxt_o.desyncs   = ds_count;
        if (ds_count >= cfg_i.esc_count) begin
          nxt_o.reconnects = esc_reconn;
          nxt_o.level      = esc_level;
          action_o         = esc_action;
        end
      end
      REQ_FORCE: begin
        if (cur_i.level == LVL_IDLE || cur_i.level == LVL_SOFT) begin
          nxt_o.reconnects = esc_reconn;
          nxt_o.level      = esc_level;
          action_o         = esc_action;
        end else if (cur_i.level == LVL_HARD) begin
          nxt_o.level = LVL_DISC;
          action_o    = ACT_DISC;
        end
      end
      REQ_RESET: begin
        nxt_o = '0;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

[sv/recovery_escalation_controller.sv]
// Top level of the link recovery escalation controller.
// Takes one event per clock on the s_axis side while results drain and returns one
// result per event on the m_axis side: the event first lands in an input register,
// then the event rules update the level and counters and the result is
// captured in an output register. The output register and the input register form
// a two-entry pipeline, so a new event is accepted every cycle as long as results
// drain; a stalled result holds back at most one further event. Configuration
// writes are taken in any cycle (cfg_ready_o is always high); write them only while
// no event is in flight. Index 0 max snapshot retries, 1 max reconnect attempts,
// 2 desync window ticks, 3 desync escalate count; other indexes are ignored.
module recovery_escalation_controller
  import rec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Event stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TickW-1:0]    s_axis_tdata,   // [31:0] event_tick
  input  logic [ReqW-1:0]     s_axis_tuser,   // [2:0] req_type
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [1:0] action, [3:2] level,
                                              // [11:4] retries_now,
                                              // [19:12] reconnects_now,
                                              // [27:20] desyncs_now, [31:28] zero
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t             cfg;
  state_t           st_q, st_d;
  logic             in_vld_q;
  logic [ReqW-1:0]  in_req_q;
  logic [TickW-1:0] in_tick_q;
  logic             out_vld_q;
  logic [ActW-1:0]  out_act_q, step_act;
  state_t           out_st_q;
  logic             advance;

  assign cfg_ready_o = 1'b1;

  rec_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  rec_step u_step (
    .req_i    (in_req_q),
    .tick_i   (in_tick_q),
    .cfg_i    (cfg),
    .cur_i    (st_q),
    .nxt_o    (st_d),
    .action_o (step_act)
  );

  // Move the registered event into the result register when it is free
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q  <= s_axis_tuser;
      in_tick_q <= s_axis_tdata;
    end
  end

  // Controller state, updated once per event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_act_q <= step_act;
      out_st_q  <= st_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - ActW - LvlW - 3*CntW){1'b0}},
                          out_st_q.desyncs, out_st_q.reconnects, out_st_q.retries,
                          out_st_q.level, out_act_q};

`ifndef ASSERT_OFF
  // A disconnect request always reports the disconnecting level
  a_disc_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_act_q == ACT_DISC) |-> (out_st_q.level == LVL_DISC))
    else $error("disconnect action without disconnecting level");

  // A hard reconnect request always reports the hard reconnecting level
  a_hard_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_act_q == ACT_HARD) |-> (out_st_q.level == LVL_HARD))
    else $error("hard reconnect action without hard level");

  // A reset event clears the whole controller state
  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_req_q == REQ_RESET) |=> (st_q == '0))
    else $error("reset event left state behind");

  // Backpressure only while an event waits in the input register
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_vld_q && out_vld_q && !m_axis_tready))
    else $error("input stalled without a pending event");

  // State moves only when an event passes to the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(st_q))
    else $error("state changed without an event");
`endif

endmodule

[tb/rec_checker.sv]
// Scoreboard for the recovery escalation controller: predicts each event's result and compares.
module rec_checker
  import rec_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [TickW-1:0]    s_tdata_i,    // [31:0] event_tick
  input  logic [ReqW-1:0]     s_tuser_i,    // [2:0] req_type
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,    // [1:0] action, [3:2] level, [11:4] retries,
                                            // [19:12] reconnects, [27:20] desyncs
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         err_count_o,
  output int unsigned         results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [LvlW-1:0] level;
    logic [CntW-1:0] retries;
    logic [CntW-1:0] reconnects;
    logic [CntW-1:0] desyncs;
  } outcome_t;

  cfg_t        regs;
  state_t      st;
  outcome_t    outcome_q[$];
  int unsigned n_err;
  int unsigned n_results;

  // Counter increment that sticks at the top value
  function automatic logic [CntW-1:0] count_up(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = v;
    if (r != CNT_MAX) r = r + 1'b1;
    return r;
  endfunction

  // Move to hard reconnect, or on to disconnect once attempts run out
  function automatic logic [ActW-1:0] climb_to_hard();
    st.level      = LVL_HARD;
    st.reconnects = count_up(st.reconnects);
    if (st.reconnects > regs.max_reconn) begin
      st.level = LVL_DISC;
      return ACT_DISC;
    end
    return ACT_HARD;
  endfunction

  // Apply one event to the predicted state and return the outcome it reports
  function automatic outcome_t apply_event(input logic [ReqW-1:0] req,
                                           input logic [TickW-1:0] tick);
    logic [ActW-1:0]  act;
    logic [TickW-1:0] span;
    outcome_t         o;
    act = ACT_NONE;
    case (req)
      REQ_SUCCESS: begin
        st.retries    = '0;
        st.reconnects = '0;
        st.desyncs    = '0;
        st.level      = LVL_IDLE;
      end
      REQ_SNAPFAIL: begin
        st.retries = count_up(st.retries);
        if (st.level == LVL_IDLE) st.level = LVL_SOFT;
        if (st.retries > regs.max_retries) act = climb_to_hard();
        else act = ACT_SOFT;
      end
      REQ_DESYNC: begin
        if (st.desyncs == '0) st.win_start = tick;
        span = tick - st.win_start;
        if (span > regs.window_ticks) begin
          st.desyncs   = '0;
          st.win_start = tick;
        end
        st.desyncs = count_up(st.desyncs);
        if (st.desyncs >= regs.esc_count) act = climb_to_hard();
      end
      REQ_FORCE: begin
        if (st.level == LVL_IDLE || st.level == LVL_SOFT) begin
          act = climb_to_hard();
        end else if (st.level == LVL_HARD) begin
          st.level = LVL_DISC;
          act      = ACT_DISC;
        end
      end
      REQ_RESET: begin
        st.level      = LVL_IDLE;
        st.retries    = '0;
        st.reconnects = '0;
        st.desyncs    = '0;
        st.win_start  = '0;
      end
      default: ;
    endcase
    o.action     = act;
    o.level      = st.level;
    o.retries    = st.retries;
    o.reconnects = st.reconnects;
    o.desyncs    = st.desyncs;
    return o;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t rec_checker: %s mismatch, expected %0d, actual %0d",
               $time, name, want, got);
      n_err++;
    end
  endfunction

  // Watch the three channels; results are checked before new events are queued
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      regs.max_retries  = RST_MAX_RETRIES;
      regs.max_reconn   = RST_MAX_RECONN;
      regs.window_ticks = RST_WINDOW_TICKS;
      regs.esc_count    = RST_ESC_COUNT;
      st                = '0;
      outcome_q.delete();
      n_err             = 0;
      n_results         = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        n_results++;
        if (outcome_q.size() == 0) begin
          $display("%0t rec_checker: unexpected result, expected none, actual %h",
                   $time, m_tdata_i);
          n_err++;
        end else begin
          want = outcome_q.pop_front();
          check_field("action", 32'(want.action), 32'(m_tdata_i[1:0]));
          check_field("level", 32'(want.level), 32'(m_tdata_i[3:2]));
          check_field("retries", 32'(want.retries), 32'(m_tdata_i[11:4]));
          check_field("reconnects", 32'(want.reconnects), 32'(m_tdata_i[19:12]));
          check_field("desyncs", 32'(want.desyncs), 32'(m_tdata_i[27:20]));
        end
      end
      if (s_tvalid_i && s_tready_i) outcome_q.push_back(apply_event(s_tuser_i, s_tdata_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_RETRIES:  regs.max_retries  = cfg_data_i[CntW-1:0];
          REG_MAX_RECONN:   regs.max_reconn   = cfg_data_i[CntW-1:0];
          REG_WINDOW_TICKS: regs.window_ticks = cfg_data_i[TickW-1:0];
          REG_ESC_COUNT:    regs.esc_count    = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
    end
    err_count_o <= n_err;
    results_o   <= n_results;
  end

endmodule

[tb/tb.sv]
// Top-level testbench for the recovery escalation controller: stimulus, stalls and verdict.
module tb
  import rec_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_PHASES  = 8;

  // Config flavors used by the random phases
  typedef enum int {
    CFG_SMALL, CFG_ZERO, CFG_MAX, CFG_RANDOM, CFG_RECONN_SAT
  } cfg_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TickW-1:0]    s_axis_tdata = '0;   // [31:0] event_tick
  logic [ReqW-1:0]     s_axis_tuser = '0;   // [2:0] req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [1:0] action, [3:2] level, [11:4] retries,
                                            // [19:12] reconnects, [27:20] desyncs
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned err_count;
  int unsigned results_seen;
  int unsigned n_sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  cfg_t        cur_cfg;
  logic [TickW-1:0] tick_now = '0;

  always #2 clk_i = ~clk_i;

  recovery_escalation_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  rec_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .err_count_o (err_count),
    .results_o   (results_seen)
  );

  // Run watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side: random stall before taking each result
  initial begin
    int stall;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // One event request, with a random gap ahead of it
  task automatic send_event(input logic [ReqW-1:0] req, input logic [TickW-1:0] tick);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= tick;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // Stop sending and hold off until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_seen != n_sent) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all registers back to back; a stray index goes first and must be ignored
  task automatic program_regs(input cfg_t c);
    cfg_put(CfgIdxW'($urandom_range(4, 7)), $urandom());
    cfg_put(REG_MAX_RETRIES, {24'($urandom()), c.max_retries});
    cfg_put(REG_MAX_RECONN, {24'($urandom()), c.max_reconn});
    cfg_put(REG_WINDOW_TICKS, c.window_ticks);
    cfg_put(REG_ESC_COUNT, {24'($urandom()), c.esc_count});
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t make_cfg(input cfg_mode_e mode);
    cfg_t c;
    case (mode)
      CFG_SMALL: begin
        c.max_retries  = CntW'($urandom_range(0, 4));
        c.max_reconn   = CntW'($urandom_range(0, 4));
        c.window_ticks = $urandom_range(0, 200);
        c.esc_count    = CntW'($urandom_range(0, 4));
      end
      CFG_ZERO: c = '0;
      CFG_MAX:  c = '1;
      CFG_RECONN_SAT: begin
        c.max_retries  = '0;
        c.max_reconn   = '1;
        c.window_ticks = '1;
        c.esc_count    = 8'd1;
      end
      default: begin
        c.max_retries  = CntW'($urandom());
        c.max_reconn   = CntW'($urandom());
        c.window_ticks = $urandom();
        c.esc_count    = CntW'($urandom());
      end
    endcase
    return c;
  endfunction

  // Desync stamps mostly move forward in steps around the window length
  function automatic logic [TickW-1:0] next_desync_tick();
    int unsigned r;
    int unsigned step;
    r    = $urandom_range(0, 99);
    step = (cur_cfg.window_ticks < 1000) ? cur_cfg.window_ticks * 2 + 2 : 1000;
    if (r < 70) tick_now = tick_now + $urandom_range(0, step);
    else if (r < 85) tick_now = tick_now + cur_cfg.window_ticks + $urandom_range(0, 1);
    else tick_now = $urandom();
    return tick_now;
  endfunction

  // Pick a random event; without clears, counters are driven toward saturation
  task automatic send_random(input bit no_clear);
    int unsigned r;
    logic [ReqW-1:0] req;
    r = $urandom_range(0, 99);
    if (no_clear) begin
      if (r < 55) req = REQ_SNAPFAIL;
      else if (r < 90) req = REQ_DESYNC;
      else if (r < 95) req = REQ_FORCE;
      else req = ReqW'($urandom_range(5, 7));
    end else begin
      if (r < 15) req = REQ_SUCCESS;
      else if (r < 40) req = REQ_SNAPFAIL;
      else if (r < 75) req = REQ_DESYNC;
      else if (r < 87) req = REQ_FORCE;
      else if (r < 92) req = REQ_RESET;
      else req = ReqW'($urandom_range(5, 7));
    end
    send_event(req, (req == REQ_DESYNC) ? next_desync_tick() : $urandom());
  endtask

  initial begin
    int unsigned phase_items [NUM_PHASES] = '{150, 150, 650, 150, 500, 150, 100, 100};
    cfg_mode_e   phase_mode  [NUM_PHASES] = '{CFG_SMALL, CFG_ZERO, CFG_MAX, CFG_RANDOM,
                                              CFG_RECONN_SAT, CFG_SMALL, CFG_RANDOM,
                                              CFG_SMALL};
    cfg_t c;
    cur_cfg.max_retries  = RST_MAX_RETRIES;
    cur_cfg.max_reconn   = RST_MAX_RECONN;
    cur_cfg.window_ticks = RST_WINDOW_TICKS;
    cur_cfg.esc_count    = RST_ESC_COUNT;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events under the reset register values
    send_event(REQ_SUCCESS, '1);
    send_event(REQ_SNAPFAIL, '0);
    send_event(REQ_SNAPFAIL, $urandom());
    send_event(REQ_SNAPFAIL, $urandom());
    send_event(REQ_SNAPFAIL, $urandom());     // retries over the limit: hard reconnect
    send_event(REQ_FORCE, $urandom());        // hard to disconnect
    send_event(REQ_FORCE, $urandom());        // already disconnecting: no change
    send_event(REQ_SNAPFAIL, $urandom());     // escalation drops back to hard
    send_event(REQ_SNAPFAIL, $urandom());
    send_event(REQ_SNAPFAIL, $urandom());     // reconnects exhausted: disconnect
    send_event(ReqW'(5), '1);                 // unused codes
    send_event(ReqW'(6), '0);
    send_event(ReqW'(7), '1);
    send_event(REQ_RESET, $urandom());
    send_event(REQ_FORCE, $urandom());        // force from idle
    send_event(REQ_SUCCESS, $urandom());
    send_event(REQ_DESYNC, 32'd1000);         // opens the window
    send_event(REQ_DESYNC, 32'd1600);         // exactly at the window edge, still inside
    send_event(REQ_DESYNC, 32'd1600);         // third desync escalates
    send_event(REQ_DESYNC, 32'd2201);         // past the window: count restarts
    send_event(REQ_RESET, $urandom());
    send_event(REQ_DESYNC, 32'hFFFF_FF00);
    send_event(REQ_DESYNC, 32'h0000_0100);    // tick wrapped, still inside the window
    send_event(REQ_DESYNC, 32'h0000_0359);    // wrapped and outside the window
    wait_drained();

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      c = make_cfg(phase_mode[p]);
      program_regs(c);
      calm = (p % 3 == 1);
      if (p % 2 == 0) send_event(REQ_RESET, $urandom());
      for (int i = 0; i < phase_items[p]; i++) begin
        send_random(phase_mode[p] == CFG_MAX || phase_mode[p] == CFG_RECONN_SAT);
        // mid-phase hold-off until the pipeline is empty
        if (i == phase_items[p] / 2 && p == 3) wait_drained();
      end
      wait_drained();
    end

    // Let stray results show up before the verdict
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
